// ===== rtl/core/rlu_pkg.sv =====
`default_nettype none

package rlu_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int W          = 24;
	localparam int AW         = 23;
	localparam int PW         = 2 * W;
	localparam int SW         = 2 * W + 2;
	localparam int NUM_STAGES = 15;
	localparam int CFG_IW     = 3;

	typedef logic signed [W-1:0]  fx_t;
	typedef logic signed [PW-1:0] pr_t;
	typedef logic signed [SW-1:0] sw_t;
	typedef logic [AW-1:0]        asp_t;

	localparam sw_t ONE_SW  = sw_t'(1) <<< FRAC_BITS;
	localparam sw_t HALF_SW = sw_t'(1) <<< (FRAC_BITS - 1);
	localparam sw_t MAX_SW  = sw_t'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam sw_t MIN_SW  = -(sw_t'(1) <<< (W - 1));

	// one in fixed point, clipped to the unsigned register range
	localparam asp_t REG_ONE = (FRAC_BITS >= AW) ? '1 : asp_t'(64'd1 << FRAC_BITS);

	typedef enum logic [CFG_IW-1:0] {
		REG_K0,
		REG_K1,
		REG_K2,
		REG_K3,
		REG_LENS_OFFSET,
		REG_EYE_ASPECT,
		REG_INV_EYE_ASPECT
	} cfg_reg_t;

	typedef struct packed {
		fx_t  tex_x;
		fx_t  tex_y;
		logic eye;
	} in_t;

	typedef struct packed {
		fx_t  src_x;
		fx_t  src_y;
		logic saturated;
	} out_t;

	function automatic logic ovf(input sw_t v);
		return (v > MAX_SW) || (v < MIN_SW);
	endfunction

	function automatic fx_t sat(input sw_t v);
		if (v > MAX_SW) begin
			return fx_t'(MAX_SW);
		end else if (v < MIN_SW) begin
			return fx_t'(MIN_SW);
		end
		return fx_t'(v);
	endfunction

	// round to FRAC_BITS fraction bits, halves toward plus infinity
	function automatic sw_t rnd_frac(input sw_t v);
		return (v + HALF_SW) >>> FRAC_BITS;
	endfunction

	function automatic sw_t rnd_half(input sw_t v);
		return (v + sw_t'(1)) >>> 1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/radial_lens_undistort_lookup.sv =====
`default_nettype none

// channel   direction  payload                        transaction
// in        in         tex_x, tex_y, eye (in_t)       in_valid & in_ready
// out       out        src_x, src_y, saturated        out_valid & out_ready
// cfg       in         cfg_index, cfg_data            cfg_valid & cfg_ready
//
// fifteen register stages, one transaction per cycle while out_ready stays high
// each stage holds at most two multipliers; the horner chain sets the depth
// reset clears the valid bits and loads the coefficient registers
// a stage moves when it is empty or the next one moves, so bubbles collapse
// and input is taken while a result waits at the output register

module radial_lens_undistort_lookup (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  rlu_pkg::in_t               in_data,
	output logic                       out_valid,
	input  wire                        out_ready,
	output rlu_pkg::out_t              out_data,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [rlu_pkg::CFG_IW-1:0] cfg_index,
	input  wire  [rlu_pkg::W-1:0]      cfg_data
);
	import rlu_pkg::*;

	typedef struct packed {
		logic f;
		fx_t  off;
		fx_t  rx;
		fx_t  ry;
		fx_t  sy;
		fx_t  r2;
		fx_t  p;
		fx_t  ux;
		fx_t  dy;
		pr_t  pa;
		pr_t  pb;
	} st_t;

	fx_t  k0_q, k1_q, k2_q, k3_q, lens_offset_q;
	asp_t eye_aspect_q, inv_eye_aspect_q;

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] en;
	logic [NUM_STAGES:1] vin;

	st_t d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7, d_s8;
	st_t d_s9, d_s10, d_s11, d_s12, d_s13, d_s14, d_s15;
	st_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13, n14, n15;

	sw_t neg_off, x2, y2, sum_rx, sum_r2;
	sw_t q7, q9, q11, dxw, dyw, uxw, uyw;
	fx_t sx, sy, m7, m9, m11, dx, uy;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k0_q             <= fx_t'(REG_ONE);
			k1_q             <= '0;
			k2_q             <= '0;
			k3_q             <= '0;
			lens_offset_q    <= '0;
			eye_aspect_q     <= REG_ONE;
			inv_eye_aspect_q <= REG_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_K0:             k0_q <= cfg_data;
				REG_K1:             k1_q <= cfg_data;
				REG_K2:             k2_q <= cfg_data;
				REG_K3:             k3_q <= cfg_data;
				REG_LENS_OFFSET:    lens_offset_q <= cfg_data;
				REG_EYE_ASPECT:     eye_aspect_q <= cfg_data[AW-1:0];
				REG_INV_EYE_ASPECT: inv_eye_aspect_q <= cfg_data[AW-1:0];
				default: begin
				end
			endcase
		end
	end

	// flow control
	always_comb begin
		en[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vin      = {vld_q[NUM_STAGES-1:1], in_valid};
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vin[i];
				end
			end
		end
	end

	// datapath
	always_comb begin
		// texture to screen, lens shift
		n1 = '0;
		neg_off = -sw_t'(lens_offset_q);
		if (in_data.eye) begin
			n1.off = lens_offset_q;
		end else begin
			n1.off = sat(neg_off);
			n1.f   = ovf(neg_off);
		end
		x2 = (sw_t'(in_data.tex_x) <<< 1) - ONE_SW;
		y2 = (sw_t'(in_data.tex_y) <<< 1) - ONE_SW;
		sx = sat(x2);
		sy = sat(y2);
		sum_rx = sw_t'(sx) + sw_t'(n1.off);
		n1.sy = sy;
		n1.rx = sat(sum_rx);
		n1.f  = n1.f | ovf(x2) | ovf(y2) | ovf(sum_rx);

		// aspect product and rx squared
		n2 = d_s1;
		n2.pa = d_s1.sy * fx_t'({1'b0, inv_eye_aspect_q});
		n2.pb = d_s1.rx * d_s1.rx;

		n3 = d_s2;
		n3.ry = sat(rnd_frac(sw_t'(d_s2.pa)));
		n3.f  = d_s2.f | ovf(rnd_frac(sw_t'(d_s2.pa)));

		n4 = d_s3;
		n4.pa = d_s3.ry * d_s3.ry;

		n5 = d_s4;
		sum_r2 = rnd_frac(sw_t'(d_s4.pa) + sw_t'(d_s4.pb));
		n5.r2 = sat(sum_r2);
		n5.f  = d_s4.f | ovf(sum_r2);

		// horner steps
		n6 = d_s5;
		n6.pa = d_s5.r2 * k3_q;

		n7 = d_s6;
		m7 = sat(rnd_frac(sw_t'(d_s6.pa)));
		q7 = sw_t'(k2_q) + sw_t'(m7);
		n7.p = sat(q7);
		n7.f = d_s6.f | ovf(rnd_frac(sw_t'(d_s6.pa))) | ovf(q7);

		n8 = d_s7;
		n8.pa = d_s7.r2 * d_s7.p;

		n9 = d_s8;
		m9 = sat(rnd_frac(sw_t'(d_s8.pa)));
		q9 = sw_t'(k1_q) + sw_t'(m9);
		n9.p = sat(q9);
		n9.f = d_s8.f | ovf(rnd_frac(sw_t'(d_s8.pa))) | ovf(q9);

		n10 = d_s9;
		n10.pa = d_s9.r2 * d_s9.p;

		n11 = d_s10;
		m11 = sat(rnd_frac(sw_t'(d_s10.pa)));
		q11 = sw_t'(k0_q) + sw_t'(m11);
		n11.p = sat(q11);
		n11.f = d_s10.f | ovf(rnd_frac(sw_t'(d_s10.pa))) | ovf(q11);

		// scale both axes
		n12 = d_s11;
		n12.pa = d_s11.rx * d_s11.p;
		n12.pb = d_s11.ry * d_s11.p;

		n13 = d_s12;
		dxw = rnd_frac(sw_t'(d_s12.pa));
		dyw = rnd_frac(sw_t'(d_s12.pb));
		dx  = sat(dxw);
		uxw = sw_t'(dx) - sw_t'(d_s12.off);
		n13.dy = sat(dyw);
		n13.ux = sat(uxw);
		n13.f  = d_s12.f | ovf(dxw) | ovf(dyw) | ovf(uxw);

		n14 = d_s13;
		n14.pa = d_s13.dy * fx_t'({1'b0, eye_aspect_q});

		// back to texture space, ux and dy carry the results
		n15 = d_s14;
		uyw = rnd_frac(sw_t'(d_s14.pa));
		uy  = sat(uyw);
		n15.ux = sat(rnd_half(sw_t'(d_s14.ux) + ONE_SW));
		n15.dy = sat(rnd_half(sw_t'(uy) + ONE_SW));
		n15.f  = d_s14.f | ovf(uyw)
			| ovf(rnd_half(sw_t'(d_s14.ux) + ONE_SW))
			| ovf(rnd_half(sw_t'(uy) + ONE_SW));
	end

	always_ff @(posedge clk) begin
		if (en[1] && vin[1]) d_s1 <= n1;
		if (en[2] && vin[2]) d_s2 <= n2;
		if (en[3] && vin[3]) d_s3 <= n3;
		if (en[4] && vin[4]) d_s4 <= n4;
		if (en[5] && vin[5]) d_s5 <= n5;
		if (en[6] && vin[6]) d_s6 <= n6;
		if (en[7] && vin[7]) d_s7 <= n7;
		if (en[8] && vin[8]) d_s8 <= n8;
		if (en[9] && vin[9]) d_s9 <= n9;
		if (en[10] && vin[10]) d_s10 <= n10;
		if (en[11] && vin[11]) d_s11 <= n11;
		if (en[12] && vin[12]) d_s12 <= n12;
		if (en[13] && vin[13]) d_s13 <= n13;
		if (en[14] && vin[14]) d_s14 <= n14;
		if (en[15] && vin[15]) d_s15 <= n15;
	end

	assign out_valid          = vld_q[NUM_STAGES];
	assign out_data.src_x     = d_s15.ux;
	assign out_data.src_y     = d_s15.dy;
	assign out_data.saturated = d_s15.f;

endmodule

`default_nettype wire
